// ----- design/ats_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ats_pkg
// shared constants, payload types and state codes of the alarm table scheduler
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int MAX_RESULTS = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W    = 8;
  localparam int DELAY_W = 31;
  localparam int AUX_W   = 32;
  localparam int TIME_W  = 64;
  localparam int UNITS_W = 20;
  localparam int PROD_W  = DELAY_W + UNITS_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_UNITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OVF_ID     = 1'b1;

  localparam logic [UNITS_W-1:0] TIME_UNITS_RESET = 20'd1000;
  localparam logic [ID_W-1:0]    OVF_ID_RESET     = 8'd3;

  localparam logic FUNC_ACTIVATE = 1'b0;
  localparam logic FUNC_TICK     = 1'b1;

  localparam logic RK_FIRED    = 1'b0;
  localparam logic RK_OVERFLOW = 1'b1;

  typedef struct packed {
    logic               func;
    logic [ID_W-1:0]    event_id;
    logic [DELAY_W-1:0] delay_units;
    logic               periodic;
    logic [AUX_W-1:0]   aux_data;
    logic [TIME_W-1:0]  now_time;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [ID_W-1:0]  fired_event;
    logic [AUX_W-1:0] fired_aux;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [UNITS_W-1:0] time_units;
    logic [ID_W-1:0]    ovf_id;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_ACTIVATE,
    CMD_CANCEL,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
    logic               periodic;
    logic [AUX_W-1:0]   aux;
    logic [TIME_W-1:0]  now;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_OVERFLOW,
    ST_MUL,
    ST_APPEND,
    ST_SCAN,
    ST_REARM,
    ST_FLUSH
  } back_state_t;

endpackage

// ----- design/ats_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ats_front
// accepts input transfers, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module ats_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ats_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output ats_pkg::cmd_t     cmd_data
);
  import ats_pkg::*;

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;
  cmd_t              cls;

  // classify
  always_comb begin
    cls.id       = in_data.event_id;
    cls.delay    = in_data.delay_units;
    cls.periodic = in_data.periodic;
    cls.aux      = in_data.aux_data;
    cls.now      = in_data.now_time;
    if (in_data.func == FUNC_TICK) begin
      cls.kind = CMD_TICK;
    end else if (in_data.delay_units == '0) begin
      cls.kind = CMD_CANCEL;
    end else begin
      cls.kind = CMD_ACTIVATE;
    end
  end

  assign in_ready  = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd_data  = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- design/ats_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ats_back
// alarm table, scan sequencer, shared multiplier and result register
// ----------------------------------------------------------------------------
module ats_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ats_pkg::cfg_t      cfg,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  ats_pkg::cmd_t      cmd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ats_pkg::out_item_t out_data
);
  import ats_pkg::*;

  logic [ID_W-1:0]    id_r  [TABLE_DEPTH];
  logic [TIME_W-1:0]  due_r [TABLE_DEPTH];
  logic [DELAY_W-1:0] dly_r [TABLE_DEPTH];
  logic [AUX_W-1:0]   aux_r [TABLE_DEPTH];
  logic               per_r [TABLE_DEPTH];

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   k_r;
  logic [RES_W-1:0]   n_r;
  logic [PROD_W-1:0]  prod_r;
  logic               pend_valid_r;
  out_item_t          pend_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [IDX_W-1:0]   k_idx;
  logic [IDX_W-1:0]   app_idx;
  logic [ID_W-1:0]    sel_id;
  logic [TIME_W-1:0]  sel_due;
  logic [DELAY_W-1:0] sel_dly;
  logic [AUX_W-1:0]   sel_aux;
  logic               sel_per;
  logic               in_range;
  logic               scan_live;
  logic               expired;
  logic               push_ok;
  logic [DELAY_W-1:0] mul_a;
  logic [TIME_W-1:0]  new_due;

  logic               drop_en;
  logic               k_inc;
  logic               fire;
  logic               push;
  out_item_t          push_item;
  logic               pend_clr;
  logic               append;
  logic               rearm;
  logic               mul_en;

  assign k_idx     = k_r[IDX_W-1:0];
  assign app_idx   = count_r[IDX_W-1:0];
  assign sel_id    = id_r[k_idx];
  assign sel_due   = due_r[k_idx];
  assign sel_dly   = dly_r[k_idx];
  assign sel_aux   = aux_r[k_idx];
  assign sel_per   = per_r[k_idx];
  assign in_range  = (k_r < count_r);
  assign scan_live = in_range && (n_r < RES_W'(MAX_RESULTS));
  assign expired   = (sel_due <= cmd_r.now);
  assign push_ok   = !out_valid_r || out_ready;
  assign mul_a     = (cmd_r.kind == CMD_TICK) ? sel_dly : cmd_r.delay;
  assign new_due   = cmd_r.now + TIME_W'(prod_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd_data.kind == CMD_TICK) ? ST_SCAN : ST_REMOVE;
        end
      end
      ST_REMOVE: begin
        if (!in_range) begin
          if (cmd_r.kind == CMD_CANCEL) begin
            state_nxt = ST_IDLE;
          end else if (count_r >= CNT_W'(TABLE_DEPTH)) begin
            state_nxt = ST_OVERFLOW;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_OVERFLOW: begin
        if (push_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        state_nxt = (cmd_r.kind == CMD_TICK) ? ST_REARM : ST_APPEND;
      end
      ST_APPEND: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (!scan_live) begin
          state_nxt = ST_FLUSH;
        end else if (fire && sel_per) begin
          state_nxt = ST_MUL;
        end
      end
      ST_REARM: begin
        state_nxt = ST_SCAN;
      end
      ST_FLUSH: begin
        if (!pend_valid_r || push_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop   = 1'b0;
    drop_en   = 1'b0;
    k_inc     = 1'b0;
    fire      = 1'b0;
    push      = 1'b0;
    push_item = pend_r;
    pend_clr  = 1'b0;
    append    = 1'b0;
    rearm     = 1'b0;
    mul_en    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
      end
      ST_REMOVE: begin
        if (in_range) begin
          if (sel_id == cmd_r.id) begin
            drop_en = 1'b1;
          end else begin
            k_inc = 1'b1;
          end
        end
      end
      ST_OVERFLOW: begin
        push                  = push_ok;
        push_item.result_kind = RK_OVERFLOW;
        push_item.fired_event = cfg.ovf_id;
        push_item.fired_aux   = '0;
        push_item.last        = 1'b1;
      end
      ST_MUL: begin
        mul_en = 1'b1;
      end
      ST_APPEND: begin
        append = 1'b1;
      end
      ST_SCAN: begin
        if (scan_live) begin
          if (expired) begin
            if (!pend_valid_r || push_ok) begin
              fire    = 1'b1;
              push    = pend_valid_r;
              drop_en = !sel_per;
            end
          end else begin
            k_inc = 1'b1;
          end
        end
      end
      ST_REARM: begin
        rearm = 1'b1;
        k_inc = 1'b1;
      end
      ST_FLUSH: begin
        push           = pend_valid_r && push_ok;
        pend_clr       = push;
        push_item.last = 1'b1;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      k_r          <= '0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (drop_en) begin
        count_r <= count_r - 1'b1;
      end else if (append) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd_pop) begin
        k_r <= '0;
      end else if (k_inc) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd_pop) begin
        n_r <= '0;
      end else if (fire) begin
        n_r <= n_r + 1'b1;
      end
      if (fire) begin
        pend_valid_r <= 1'b1;
      end else if (pend_clr) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd_data;
    end
    if (mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(cfg.time_units);
    end
    if (fire) begin
      pend_r.result_kind <= RK_FIRED;
      pend_r.fired_event <= sel_id;
      pend_r.fired_aux   <= sel_aux;
      pend_r.last        <= 1'b0;
    end
    if (push) begin
      out_data_r <= push_item;
    end
  end

  // table: shift-down removal, append at the tail, re-arm in place
  always_ff @(posedge clk) begin
    for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
      if (drop_en && (CNT_W'(j) >= k_r)) begin
        id_r[j]  <= id_r[j+1];
        due_r[j] <= due_r[j+1];
        dly_r[j] <= dly_r[j+1];
        aux_r[j] <= aux_r[j+1];
        per_r[j] <= per_r[j+1];
      end
    end
    if (append) begin
      id_r[app_idx]  <= cmd_r.id;
      due_r[app_idx] <= new_due;
      dly_r[app_idx] <= cmd_r.delay;
      aux_r[app_idx] <= cmd_r.aux;
      per_r[app_idx] <= cmd_r.periodic;
    end
    if (rearm) begin
      due_r[k_idx] <= new_due;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= count_r)
    else $error("scan index past entry count");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("pending result left over at idle");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.result_kind == RK_OVERFLOW)) |-> out_data_r.last)
    else $error("overflow result not marked last");

  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RES_W'(MAX_RESULTS))
    else $error("too many results for one tick");

endmodule

// ----- design/alarm_table_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_table_scheduler
// alarm table with activate, cancel and tick commands, decoupled front and back
// ----------------------------------------------------------------------------
// activate: id search one entry a cycle, then multiply and append (overflow result if the table is full)
// tick: scan of the table; each periodic alarm fired is re-armed through the shared multiplier
// results leave through an output register, last one after the scan completes
// a two-deep command queue takes new transfers while the back end is busy
// reset clears the entry count, queue and sequencer; table contents are not cleared
module alarm_table_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ats_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ats_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [ats_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ats_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ats_pkg::*;

  cfg_t cfg_r;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_units <= TIME_UNITS_RESET;
      cfg_r.ovf_id     <= OVF_ID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_UNITS: cfg_r.time_units <= cfg_wdata[UNITS_W-1:0];
        REG_OVF_ID:     cfg_r.ovf_id     <= cfg_wdata[ID_W-1:0];
      endcase
    end
  end

  ats_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data)
  );

  ats_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
